/* hdl/rtps_pkg.sv */
`default_nettype none
package rtps_pkg;
   localparam int TASK_SLOTS_DEF = 16;
   localparam int PRIORITY_LEVELS_DEF = 8;
   localparam int TASK_W = 4;
   localparam int PRIO_W = 3;
   localparam int MODE_W = 3;
   localparam int STATUS_W = 2;
   localparam int TIME_W = 32;

   localparam logic [MODE_W-1:0] MODE_TICK    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_START   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SUSPEND = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DELAY   = 3'd4;
   localparam logic [MODE_W-1:0] MODE_DELETE  = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd2;

   typedef enum logic [1:0] {
      SLOT_FREE    = 2'd0,
      SLOT_READY   = 2'd1,
      SLOT_DELAYED = 2'd2,
      SLOT_SUSP    = 2'd3
   } slot_state_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_UNLINK,
      ST_APPEND,
      ST_DPUSH,
      ST_PICK,
      ST_WALK,
      ST_WAKE,
      ST_DONE
   } fsm_state_type;

   typedef struct packed {
      logic sel_valid;
      logic [TASK_W-1:0] sel_task;
      logic chg;
      logic [STATUS_W-1:0] status;
   } result_type;
endpackage
`default_nettype wire

/* hdl/rtps_prio_scan.sv */
`default_nettype none
module rtps_prio_scan #(
   parameter int PRIORITY_LEVELS = rtps_pkg::PRIORITY_LEVELS_DEF,
   parameter int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       scan_start,
   input  wire logic [PRIORITY_LEVELS-1:0] level_valid,
   output logic                            scan_done,
   output logic                            scan_found,
   output logic [PW-1:0]                   scan_level
);
   logic [PW:0] idx_ff, idx_in;
   logic        run_ff, run_in;
   logic        found_ff, found_in;
   logic        done_ff, done_in;

   always_comb begin
      idx_in   = idx_ff;
      run_in   = run_ff;
      found_in = found_ff;
      done_in  = 1'b0;
      if (scan_start) begin
         idx_in   = '0;
         run_in   = 1'b1;
         found_in = 1'b0;
      end else if (run_ff) begin
         if (level_valid[idx_ff[PW-1:0]]) begin
            found_in = 1'b1;
            run_in   = 1'b0;
            done_in  = 1'b1;
         end else if (idx_ff == (PW+1)'(PRIORITY_LEVELS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            idx_in = idx_ff + (PW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         run_ff   <= 1'b0;
         found_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         run_ff   <= run_in;
         found_ff <= found_in;
         done_ff  <= done_in;
      end
   end

   assign scan_done  = done_ff;
   assign scan_found = found_ff;
   assign scan_level = idx_ff[PW-1:0];
endmodule
`default_nettype wire

/* hdl/rtos_priority_task_scheduler.sv */
`default_nettype none
// Fixed-priority round-robin task scheduler over a table of task slots.
// Raise start while busy is low to issue one request; the single response
// appears on the rsp_ ports, marked by rsp_strobe, which is high for a single
// cycle, in the first idle cycle after the request, and the receiver cannot
// stall it. The rsp_ ports hold the response until the next request is taken.
// Every request passes through a decode and a done state; a create, refused or
// ignored request goes straight from decode to done. Start, suspend, delete and
// delay add an unlink state, and start and delay also an append or delay-push
// state to link the task. A pick (every tick, and a suspend, delete or delay of
// the running task) adds the priority scan, which tests the levels from 0
// upward and stops at the first that holds a ready task. A tick then walks the
// current delay list entry by entry, visiting at most TASK_SLOTS entries and
// moving each due task onto its ready list. One sequencer drives the slot table
// and one priority scanner.
module rtos_priority_task_scheduler
   import rtps_pkg::*;
#(
   parameter int TASK_SLOTS = rtps_pkg::TASK_SLOTS_DEF,
   parameter int PRIORITY_LEVELS = rtps_pkg::PRIORITY_LEVELS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [rtps_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [rtps_pkg::TASK_W-1:0]     req_task_id,
   input  wire logic [rtps_pkg::PRIO_W-1:0]     req_priority_req,
   input  wire logic [rtps_pkg::TIME_W-1:0]     req_delay_ticks,
   input  wire logic [rtps_pkg::TASK_W-1:0]     req_current_task,
   input  wire logic                            req_current_valid,
   output logic                                 rsp_strobe,
   output logic                                 rsp_selected_valid,
   output logic [rtps_pkg::TASK_W-1:0]          rsp_selected_task,
   output logic                                 rsp_change_request,
   output logic [rtps_pkg::STATUS_W-1:0]        rsp_op_status
);
   localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int PW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
   localparam int SLOTS_IN_ID = 1 << TASK_W;

   slot_state_type      sst_ff   [TASK_SLOTS];
   logic [PW-1:0]       sprio_ff [TASK_SLOTS];
   logic [SW-1:0]       snext_ff [TASK_SLOTS];
   logic [SW-1:0]       sprev_ff [TASK_SLOTS];
   logic                spv_ff   [TASK_SLOTS];
   logic                snv_ff   [TASK_SLOTS];
   logic [TIME_W-1:0]   swake_ff [TASK_SLOTS];
   logic                sep_ff   [TASK_SLOTS];
   logic [SW-1:0]       rhead_ff [PRIORITY_LEVELS];
   logic [PRIORITY_LEVELS-1:0] rvalid_ff;
   logic [SW-1:0]       dhead_ff [2];
   logic [1:0]          dvalid_ff;
   logic [TIME_W-1:0]   tick_ff;
   logic                epoch_ff;

   fsm_state_type       state_ff, state_in;
   logic [MODE_W-1:0]   mode_ff;
   logic [SW-1:0]       t_ff;
   logic [TASK_W-1:0]   tid_ff;
   logic [PRIO_W-1:0]   preq_ff;
   logic [TIME_W-1:0]   dly_ff;
   logic                is_cur_ff;
   result_type          res_ff;
   logic                pick_ff;
   logic [SW-1:0]       c_ff;
   logic                cv_ff;
   logic [SW:0]         guard_ff;
   logic                scan_start, scan_done, scan_found;
   logic [PW-1:0]       scan_level;
   logic                strobe_ff;
   logic                tid_in_range;
   logic [TIME_W-1:0]   wake_sum;
   logic                op_ignored;
   logic                walk_more;
   logic                wake_due;

   rtps_prio_scan #(.PRIORITY_LEVELS(PRIORITY_LEVELS), .PW(PW)) u_scan (
      .clock(clock), .reset(reset), .scan_start(scan_start),
      .level_valid(rvalid_ff), .scan_done(scan_done),
      .scan_found(scan_found), .scan_level(scan_level)
   );

   assign tid_in_range = (SLOTS_IN_ID <= TASK_SLOTS) ||
                         ({1'b0, tid_ff} < (TASK_W+1)'(TASK_SLOTS));
   assign wake_sum = tick_ff + dly_ff;
   assign op_ignored = (mode_ff == MODE_START && sst_ff[t_ff] == SLOT_READY) ||
                       (mode_ff == MODE_SUSPEND && sst_ff[t_ff] == SLOT_SUSP) ||
                       (mode_ff == MODE_DELAY && sst_ff[t_ff] != SLOT_READY);
   assign walk_more = cv_ff && (guard_ff < (SW+1)'(TASK_SLOTS));
   assign wake_due = (swake_ff[c_ff] <= tick_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_DECODE;
         ST_DECODE: begin
            if (mode_ff == MODE_TICK) state_in = ST_PICK;
            else if (mode_ff > MODE_DELETE || !tid_in_range || mode_ff == MODE_CREATE ||
                     sst_ff[t_ff] == SLOT_FREE || op_ignored) state_in = ST_DONE;
            else state_in = ST_UNLINK;
         end
         ST_UNLINK: begin
            case (mode_ff)
               MODE_START: state_in = ST_APPEND;
               MODE_DELAY: state_in = ST_DPUSH;
               default:    state_in = is_cur_ff ? ST_PICK : ST_DONE;
            endcase
         end
         ST_APPEND: state_in = ST_DONE;
         ST_WAKE:   state_in = ST_WALK;
         ST_DPUSH:  state_in = is_cur_ff ? ST_PICK : ST_DONE;
         ST_PICK: begin
            if (scan_done) state_in = (mode_ff == MODE_TICK) ? ST_WALK : ST_DONE;
         end
         ST_WALK: begin
            if (!walk_more) state_in = ST_DONE;
            else if (wake_due) state_in = ST_WAKE;
         end
         ST_DONE:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);
   assign scan_start = (state_ff == ST_PICK) && !pick_ff;

   function automatic logic [PW-1:0] sat_prio(input logic [PRIO_W-1:0] p);
      if (int'(p) >= PRIORITY_LEVELS) return PW'(PRIORITY_LEVELS - 1);
      return PW'(p);
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         for (int i = 0; i < TASK_SLOTS; i++) sst_ff[i] <= SLOT_FREE;
         rvalid_ff <= '0;
         dvalid_ff <= '0;
         tick_ff   <= '0;
         epoch_ff  <= 1'b0;
         strobe_ff <= 1'b0;
         pick_ff   <= 1'b0;
         cv_ff     <= 1'b0;
         guard_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= (state_ff == ST_DONE);
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  mode_ff   <= req_mode;
                  tid_ff    <= req_task_id;
                  t_ff      <= SW'(req_task_id);
                  preq_ff   <= req_priority_req;
                  dly_ff    <= req_delay_ticks;
                  is_cur_ff <= req_current_valid && (req_current_task == req_task_id);
                  res_ff    <= '0;
                  pick_ff   <= 1'b0;
               end
            end
            ST_DECODE: begin
               if (mode_ff == MODE_TICK) begin
                  tick_ff <= tick_ff + TIME_W'(1);
                  if (tick_ff == '1) epoch_ff <= ~epoch_ff;
               end else if (mode_ff > MODE_DELETE) begin
                  res_ff.status <= STATUS_IGNORED;
               end else if (!tid_in_range) begin
                  res_ff.status <= STATUS_REFUSED;
               end else if (mode_ff == MODE_CREATE) begin
                  if (sst_ff[t_ff] != SLOT_FREE) res_ff.status <= STATUS_REFUSED;
                  else begin
                     sprio_ff[t_ff] <= sat_prio(preq_ff);
                     sst_ff[t_ff] <= SLOT_SUSP;
                  end
               end else if (sst_ff[t_ff] == SLOT_FREE) begin
                  res_ff.status <= STATUS_REFUSED;
               end else if (op_ignored) begin
                  res_ff.status <= STATUS_IGNORED;
               end
            end
            ST_UNLINK: begin
               if (sst_ff[t_ff] == SLOT_READY) begin
                  if (snext_ff[t_ff] == t_ff && sprev_ff[t_ff] == t_ff)
                     rvalid_ff[sprio_ff[t_ff]] <= 1'b0;
                  else begin
                     sprev_ff[snext_ff[t_ff]] <= sprev_ff[t_ff];
                     snext_ff[sprev_ff[t_ff]] <= snext_ff[t_ff];
                     if (rvalid_ff[sprio_ff[t_ff]] && rhead_ff[sprio_ff[t_ff]] == t_ff)
                        rhead_ff[sprio_ff[t_ff]] <= snext_ff[t_ff];
                  end
               end else if (sst_ff[t_ff] == SLOT_DELAYED) begin
                  if (dvalid_ff[sep_ff[t_ff]] && dhead_ff[sep_ff[t_ff]] == t_ff) begin
                     if (snv_ff[t_ff]) begin
                        dhead_ff[sep_ff[t_ff]] <= snext_ff[t_ff];
                        spv_ff[snext_ff[t_ff]] <= 1'b0;
                     end else dvalid_ff[sep_ff[t_ff]] <= 1'b0;
                  end else if (spv_ff[t_ff]) begin
                     snext_ff[sprev_ff[t_ff]] <= snext_ff[t_ff];
                     snv_ff[sprev_ff[t_ff]] <= snv_ff[t_ff];
                     if (snv_ff[t_ff]) begin
                        sprev_ff[snext_ff[t_ff]] <= sprev_ff[t_ff];
                        spv_ff[snext_ff[t_ff]] <= 1'b1;
                     end
                  end
               end
               if (mode_ff != MODE_START && mode_ff != MODE_DELAY) begin
                  sst_ff[t_ff] <= (mode_ff == MODE_SUSPEND) ? SLOT_SUSP : SLOT_FREE;
                  res_ff.chg <= is_cur_ff;
               end
            end
            ST_APPEND, ST_WAKE: begin
               spv_ff[t_ff] <= 1'b1;
               snv_ff[t_ff] <= 1'b1;
               if (rvalid_ff[sprio_ff[t_ff]]) begin
                  snext_ff[t_ff] <= rhead_ff[sprio_ff[t_ff]];
                  sprev_ff[t_ff] <= sprev_ff[rhead_ff[sprio_ff[t_ff]]];
                  snext_ff[sprev_ff[rhead_ff[sprio_ff[t_ff]]]] <= t_ff;
                  sprev_ff[rhead_ff[sprio_ff[t_ff]]] <= t_ff;
               end else begin
                  snext_ff[t_ff] <= t_ff;
                  sprev_ff[t_ff] <= t_ff;
                  rhead_ff[sprio_ff[t_ff]] <= t_ff;
                  rvalid_ff[sprio_ff[t_ff]] <= 1'b1;
               end
               sst_ff[t_ff] <= SLOT_READY;
            end
            ST_DPUSH: begin
               swake_ff[t_ff] <= wake_sum;
               sep_ff[t_ff] <= (wake_sum < tick_ff) ? ~epoch_ff : epoch_ff;
               spv_ff[t_ff] <= 1'b0;
               if (dvalid_ff[(wake_sum < tick_ff) ? ~epoch_ff : epoch_ff]) begin
                  snext_ff[t_ff] <= dhead_ff[(wake_sum < tick_ff) ? ~epoch_ff : epoch_ff];
                  snv_ff[t_ff] <= 1'b1;
                  sprev_ff[dhead_ff[(wake_sum < tick_ff) ? ~epoch_ff : epoch_ff]] <= t_ff;
                  spv_ff[dhead_ff[(wake_sum < tick_ff) ? ~epoch_ff : epoch_ff]] <= 1'b1;
               end else snv_ff[t_ff] <= 1'b0;
               dhead_ff[(wake_sum < tick_ff) ? ~epoch_ff : epoch_ff] <= t_ff;
               dvalid_ff[(wake_sum < tick_ff) ? ~epoch_ff : epoch_ff] <= 1'b1;
               sst_ff[t_ff] <= SLOT_DELAYED;
               res_ff.chg <= is_cur_ff;
            end
            ST_PICK: begin
               pick_ff <= 1'b1;
               if (scan_done) begin
                  if (scan_found) begin
                     res_ff.sel_valid <= 1'b1;
                     res_ff.sel_task <= TASK_W'(rhead_ff[scan_level]);
                     rhead_ff[scan_level] <= snext_ff[rhead_ff[scan_level]];
                  end
                  if (mode_ff == MODE_TICK) begin
                     c_ff <= dhead_ff[epoch_ff];
                     cv_ff <= dvalid_ff[epoch_ff];
                     guard_ff <= '0;
                  end
               end
            end
            ST_WALK: begin
               if (walk_more) begin
                  guard_ff <= guard_ff + (SW+1)'(1);
                  c_ff <= snext_ff[c_ff];
                  cv_ff <= snv_ff[c_ff];
                  t_ff <= c_ff;
                  if (wake_due) begin
                     if (dvalid_ff[sep_ff[c_ff]] && dhead_ff[sep_ff[c_ff]] == c_ff) begin
                        if (snv_ff[c_ff]) begin
                           dhead_ff[sep_ff[c_ff]] <= snext_ff[c_ff];
                           spv_ff[snext_ff[c_ff]] <= 1'b0;
                        end else dvalid_ff[sep_ff[c_ff]] <= 1'b0;
                     end else if (spv_ff[c_ff]) begin
                        snext_ff[sprev_ff[c_ff]] <= snext_ff[c_ff];
                        snv_ff[sprev_ff[c_ff]] <= snv_ff[c_ff];
                        if (snv_ff[c_ff]) begin
                           sprev_ff[snext_ff[c_ff]] <= sprev_ff[c_ff];
                           spv_ff[snext_ff[c_ff]] <= 1'b1;
                        end
                     end
                  end
               end
            end
            ST_DONE: begin
               if (!res_ff.sel_valid) res_ff.sel_task <= '0;
            end
            default: ;
         endcase
      end
   end

   assign rsp_strobe         = strobe_ff;
   assign rsp_selected_valid = res_ff.sel_valid;
   assign rsp_selected_task  = res_ff.sel_valid ? res_ff.sel_task : '0;
   assign rsp_change_request = res_ff.chg;
   assign rsp_op_status      = res_ff.status;
endmodule
`default_nettype wire

/* hdl/rtps_checker.sv */
`default_nettype none
module rtps_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic       rsp_selected_valid,
   input wire logic [3:0] rsp_selected_task,
   input wire logic [1:0] rsp_op_status
);
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("strobe held");
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("busy with response");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_op_status != 2'd3) else $error("bad status");
   a_sel_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_selected_valid) |-> rsp_selected_task == 4'd0)
      else $error("stray task");
endmodule

bind rtos_priority_task_scheduler rtps_checker u_rtps_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_selected_valid(rsp_selected_valid),
   .rsp_selected_task(rsp_selected_task), .rsp_op_status(rsp_op_status)
);
`default_nettype wire
